@@ sv/qts_pkg.sv @@
// Shared types and codes for the query token scanner.
// Token kinds, error codes and the result record; no dependencies.
package qts_pkg;

  localparam int unsigned MAX_QUERY_LEN_DEF = 4096;
  localparam logic [11:0] POS_CAP = 12'hFFF;

  localparam logic [4:0] K_LPAREN = 5'd0;
  localparam logic [4:0] K_RPAREN = 5'd1;
  localparam logic [4:0] K_COLON  = 5'd2;
  localparam logic [4:0] K_EQ     = 5'd3;
  localparam logic [4:0] K_NEQ    = 5'd4;
  localparam logic [4:0] K_LT     = 5'd5;
  localparam logic [4:0] K_LTE    = 5'd6;
  localparam logic [4:0] K_GT     = 5'd7;
  localparam logic [4:0] K_GTE    = 5'd8;
  localparam logic [4:0] K_REGEX  = 5'd9;
  localparam logic [4:0] K_STRING = 5'd10;
  localparam logic [4:0] K_FIELD  = 5'd11;
  localparam logic [4:0] K_AND    = 5'd12;
  localparam logic [4:0] K_OR     = 5'd13;
  localparam logic [4:0] K_NOT    = 5'd14;
  localparam logic [4:0] K_IP     = 5'd15;
  localparam logic [4:0] K_NUMBER = 5'd16;
  localparam logic [4:0] K_CIDR   = 5'd17;
  localparam logic [4:0] K_END    = 5'd18;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNEXP     = 3'd1;
  localparam logic [2:0] ERR_BAD_OP    = 3'd2;
  localparam logic [2:0] ERR_OPEN_STR  = 3'd3;
  localparam logic [2:0] ERR_OPEN_RE   = 3'd4;
  localparam logic [2:0] ERR_NO_PREFIX = 3'd5;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [11:0] tok_start;
    logic [12:0] value_length;
    logic [7:0]  prefix_len;
    logic [2:0]  error_code;
    logic        run_last;
    logic        query_done;
  } res_t;

endpackage

@@ sv/qts_if.sv @@
// Channel interfaces for the query token scanner: character in, token out.
// Depends on nothing.
interface qts_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface qts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [11:0] tok_start;
  logic [12:0] value_length;
  logic [7:0]  prefix_len;
  logic [2:0]  error_code;
  logic        run_last;
  logic        query_done;

  modport source (output valid, output token_kind, output tok_start, output value_length,
                  output prefix_len, output error_code, output run_last, output query_done,
                  input ready);
  modport sink   (input valid, input token_kind, input tok_start, input value_length,
                  input prefix_len, input error_code, input run_last, input query_done,
                  output ready);
endinterface

@@ sv/qts_scan.sv @@
// Lexer state and single-pass step logic: one character per accepted word,
// up to two result records out. Depends on qts_pkg.
module qts_scan #(
  parameter int unsigned MAX_QUERY_LEN = qts_pkg::MAX_QUERY_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic             mode_i,
  input  logic [7:0]       char_i,
  output qts_pkg::res_t    res0_o,
  output qts_pkg::res_t    res1_o,
  output logic [1:0]       res_v_o
);
  import qts_pkg::*;

  localparam int unsigned VAL_CAP = (MAX_QUERY_LEN < 8191) ? MAX_QUERY_LEN : 8191;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LT        = 4'd1;
  localparam logic [3:0] S_GT        = 4'd2;
  localparam logic [3:0] S_EQ        = 4'd3;
  localparam logic [3:0] S_BANG      = 4'd4;
  localparam logic [3:0] S_TILDE     = 4'd5;
  localparam logic [3:0] S_REGEX     = 4'd6;
  localparam logic [3:0] S_REGEX_BSL = 4'd7;
  localparam logic [3:0] S_STRING    = 4'd8;
  localparam logic [3:0] S_STR_ESC   = 4'd9;
  localparam logic [3:0] S_WORD      = 4'd10;
  localparam logic [3:0] S_NUMBER    = 4'd11;
  localparam logic [3:0] S_PREFIX    = 4'd12;
  localparam logic [3:0] S_ERROR     = 4'd13;

  logic [3:0]  st_q, st_d;
  logic        qs_q, qs_d;
  logic [11:0] pos_q, pos_d;
  logic [11:0] ts_q, ts_d;
  logic [12:0] vc_q, vc_d;
  logic [2:0]  dots_q, dots_d;
  logic        colon_q, colon_d;
  logic [7:0]  pv_q, pv_d;
  logic        phd_q, phd_d;
  logic [2:0]  kw_q, kw_d;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [12:0] sat_add(input logic [12:0] v, input logic [1:0] k);
    logic [13:0] s;
    s = {1'b0, v} + {12'd0, k};
    if (s > 14'(VAL_CAP)) return 13'(VAL_CAP);
    return s[12:0];
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input logic [11:0] start,
                                  input logic [12:0] len, input logic [7:0] pfx,
                                  input logic [2:0] err, input logic done);
    res_t r;
    r.token_kind   = kind;
    r.tok_start    = start;
    r.value_length = len;
    r.prefix_len   = pfx;
    r.error_code   = err;
    r.run_last     = 1'b0;
    r.query_done   = done;
    return r;
  endfunction

  // keyword match masks after one more word character at index vc_q
  function automatic logic [2:0] kw_step(input logic [2:0] kw, input logic [12:0] i,
                                         input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] ok;
    u = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    ok[0] = ((i == 13'd0) && (u == "A")) || ((i == 13'd1) && (u == "N")) ||
            ((i == 13'd2) && (u == "D"));
    ok[1] = ((i == 13'd0) && (u == "O")) || ((i == 13'd1) && (u == "R"));
    ok[2] = ((i == 13'd0) && (u == "N")) || ((i == 13'd1) && (u == "O")) ||
            ((i == 13'd2) && (u == "T"));
    return kw & ok;
  endfunction

  function automatic logic [4:0] word_kind(input logic [12:0] vc, input logic [2:0] kw);
    if ((vc == 13'd3) && kw[0]) return K_AND;
    if ((vc == 13'd2) && kw[1]) return K_OR;
    if ((vc == 13'd3) && kw[2]) return K_NOT;
    return K_FIELD;
  endfunction

  // outcome of scanning c from the idle state
  logic        id_v;
  res_t        id_r;
  logic [3:0]  id_st;
  logic [11:0] id_ts;
  logic [12:0] id_vc;
  logic        id_qs;
  logic [2:0]  id_dots;
  logic        id_colon;
  logic [2:0]  id_kw;

  always_comb begin
    id_v     = 1'b0;
    id_r     = mk_res(K_END, pos_q, 13'd0, 8'd0, ERR_UNEXP, 1'b1);
    id_st    = S_IDLE;
    id_ts    = ts_q;
    id_vc    = vc_q;
    id_qs    = qs_q;
    id_dots  = dots_q;
    id_colon = colon_q;
    id_kw    = kw_q;
    if (char_i == " " || (char_i >= 8'd9 && char_i <= 8'd13)) begin
      id_st = S_IDLE;
    end else if (char_i == "(") begin
      id_v = 1'b1;
      id_r = mk_res(K_LPAREN, pos_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
    end else if (char_i == ")") begin
      id_v = 1'b1;
      id_r = mk_res(K_RPAREN, pos_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
    end else if (char_i == ":") begin
      id_v = 1'b1;
      id_r = mk_res(K_COLON, pos_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
    end else if (char_i == "<" || char_i == ">" || char_i == "=" || char_i == "!" ||
                 char_i == "~" || char_i == "\"" || char_i == "'") begin
      id_ts = pos_q;
      id_vc = 13'd0;
      case (char_i)
        "<":     id_st = S_LT;
        ">":     id_st = S_GT;
        "=":     id_st = S_EQ;
        "!":     id_st = S_BANG;
        "~":     id_st = S_TILDE;
        default: begin
          id_st = S_STRING;
          id_qs = (char_i == "'");
        end
      endcase
    end else if (is_digit(char_i)) begin
      id_st    = S_NUMBER;
      id_ts    = pos_q;
      id_vc    = 13'd1;
      id_dots  = 3'd0;
      id_colon = 1'b0;
    end else if (is_alpha(char_i) || char_i == "_" || char_i == "*") begin
      id_st = S_WORD;
      id_ts = pos_q;
      id_vc = 13'd1;
      id_kw = kw_step(3'b111, 13'd0, char_i);
    end else begin
      id_v  = 1'b1;
      id_st = S_ERROR;
    end
  end

  logic        a_v, b_v, do_idle, no_end;
  res_t        a_r, b_r;
  logic [11:0] pv_mul;

  assign pv_mul = ({4'd0, pv_q} << 3) + ({4'd0, pv_q} << 1) + {8'd0, char_i[3:0]};

  always_comb begin
    st_d    = st_q;
    qs_d    = qs_q;
    pos_d   = pos_q;
    ts_d    = ts_q;
    vc_d    = vc_q;
    dots_d  = dots_q;
    colon_d = colon_q;
    pv_d    = pv_q;
    phd_d   = phd_q;
    kw_d    = kw_q;
    a_v     = 1'b0;
    a_r     = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_NONE, 1'b0);
    b_v     = 1'b0;
    b_r     = mk_res(K_END, pos_q, 13'd0, 8'd0, ERR_NONE, 1'b1);
    do_idle = 1'b0;
    no_end  = 1'b0;
    if (mode_i) begin
      case (st_q)
        S_ERROR: no_end = 1'b1;
        S_LT: begin
          a_v = 1'b1;
          a_r = mk_res(K_LT, ts_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
        end
        S_GT: begin
          a_v = 1'b1;
          a_r = mk_res(K_GT, ts_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
        end
        S_EQ: begin
          a_v = 1'b1;
          a_r = mk_res(K_EQ, ts_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
        end
        S_BANG, S_TILDE, S_REGEX, S_REGEX_BSL, S_STRING, S_STR_ESC: begin
          a_v    = 1'b1;
          no_end = 1'b1;
          case (st_q)
            S_BANG:              a_r = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_BAD_OP, 1'b1);
            S_TILDE:             a_r = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_UNEXP, 1'b1);
            S_REGEX, S_REGEX_BSL: a_r = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_OPEN_RE, 1'b1);
            default:             a_r = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_OPEN_STR, 1'b1);
          endcase
        end
        S_WORD: begin
          a_v = 1'b1;
          a_r = mk_res(word_kind(vc_q, kw_q), ts_q, vc_q, 8'd0, ERR_NONE, 1'b0);
        end
        S_NUMBER: begin
          a_v = 1'b1;
          a_r = mk_res((colon_q || dots_q == 3'd3) ? K_IP : K_NUMBER, ts_q, vc_q, 8'd0,
                       ERR_NONE, 1'b0);
        end
        S_PREFIX: begin
          a_v = 1'b1;
          if (!phd_q) begin
            no_end = 1'b1;
            a_r    = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_NO_PREFIX, 1'b1);
          end else begin
            a_r = mk_res(K_CIDR, ts_q, vc_q, pv_q, ERR_NONE, 1'b0);
          end
        end
        default: a_v = 1'b0;
      endcase
      b_v     = !no_end;
      // new query
      st_d    = S_IDLE;
      qs_d    = 1'b0;
      pos_d   = 12'd0;
      ts_d    = 12'd0;
      vc_d    = 13'd0;
      dots_d  = 3'd0;
      colon_d = 1'b0;
      pv_d    = 8'd0;
      phd_d   = 1'b0;
      kw_d    = 3'b111;
    end else begin
      case (st_q)
        S_LT, S_GT: begin
          a_v  = 1'b1;
          st_d = S_IDLE;
          if (char_i == "=") begin
            a_r = mk_res((st_q == S_LT) ? K_LTE : K_GTE, ts_q, 13'd2, 8'd0, ERR_NONE, 1'b0);
          end else begin
            a_r     = mk_res((st_q == S_LT) ? K_LT : K_GT, ts_q, 13'd1, 8'd0, ERR_NONE, 1'b0);
            do_idle = 1'b1;
          end
        end
        S_EQ: begin
          a_v  = 1'b1;
          st_d = S_IDLE;
          a_r  = mk_res(K_EQ, ts_q, (char_i == "=") ? 13'd2 : 13'd1, 8'd0, ERR_NONE, 1'b0);
          do_idle = (char_i != "=");
        end
        S_BANG: begin
          a_v = 1'b1;
          if (char_i == "=") begin
            st_d = S_IDLE;
            a_r  = mk_res(K_NEQ, ts_q, 13'd2, 8'd0, ERR_NONE, 1'b0);
          end else begin
            st_d = S_ERROR;
            a_r  = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_BAD_OP, 1'b1);
          end
        end
        S_TILDE: begin
          if (char_i == "/") begin
            st_d = S_REGEX;
          end else begin
            a_v  = 1'b1;
            st_d = S_ERROR;
            a_r  = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_UNEXP, 1'b1);
          end
        end
        S_REGEX: begin
          if (char_i == "/") begin
            a_v  = 1'b1;
            st_d = S_IDLE;
            a_r  = mk_res(K_REGEX, ts_q, vc_q, 8'd0, ERR_NONE, 1'b0);
          end else if (char_i == "\\") begin
            st_d = S_REGEX_BSL;
          end else begin
            vc_d = sat_add(vc_q, 2'd1);
          end
        end
        S_REGEX_BSL: begin
          // an escaped slash counts once, any other escape keeps the backslash
          if (char_i == "/") begin
            vc_d = sat_add(vc_q, 2'd1);
            st_d = S_REGEX;
          end else if (char_i == "\\") begin
            vc_d = sat_add(vc_q, 2'd1);
          end else begin
            vc_d = sat_add(vc_q, 2'd2);
            st_d = S_REGEX;
          end
        end
        S_STRING: begin
          if (char_i == (qs_q ? 8'h27 : 8'h22)) begin
            a_v  = 1'b1;
            st_d = S_IDLE;
            a_r  = mk_res(K_STRING, ts_q, vc_q, 8'd0, ERR_NONE, 1'b0);
          end else if (char_i == "\\") begin
            st_d = S_STR_ESC;
          end else begin
            vc_d = sat_add(vc_q, 2'd1);
          end
        end
        S_STR_ESC: begin
          vc_d = sat_add(vc_q, 2'd1);
          st_d = S_STRING;
        end
        S_WORD: begin
          if (is_alpha(char_i) || is_digit(char_i) || char_i == "_" || char_i == "." ||
              char_i == "-" || char_i == "*") begin
            kw_d = kw_step(kw_q, vc_q, char_i);
            vc_d = sat_add(vc_q, 2'd1);
          end else begin
            a_v     = 1'b1;
            a_r     = mk_res(word_kind(vc_q, kw_q), ts_q, vc_q, 8'd0, ERR_NONE, 1'b0);
            do_idle = 1'b1;
          end
        end
        S_NUMBER: begin
          if (is_digit(char_i) || is_hex(char_i)) begin
            vc_d = sat_add(vc_q, 2'd1);
          end else if (char_i == ".") begin
            if (dots_q < 3'd4) dots_d = dots_q + 3'd1;
            vc_d = sat_add(vc_q, 2'd1);
          end else if (char_i == ":") begin
            colon_d = 1'b1;
            vc_d    = sat_add(vc_q, 2'd1);
          end else if (char_i == "/") begin
            vc_d  = sat_add(vc_q, 2'd1);
            pv_d  = 8'd0;
            phd_d = 1'b0;
            st_d  = S_PREFIX;
          end else begin
            a_v     = 1'b1;
            a_r     = mk_res((colon_q || dots_q == 3'd3) ? K_IP : K_NUMBER, ts_q, vc_q, 8'd0,
                             ERR_NONE, 1'b0);
            do_idle = 1'b1;
          end
        end
        S_PREFIX: begin
          if (is_digit(char_i)) begin
            pv_d  = (pv_mul > 12'd255) ? 8'd255 : pv_mul[7:0];
            phd_d = 1'b1;
            vc_d  = sat_add(vc_q, 2'd1);
          end else if (!phd_q) begin
            a_v  = 1'b1;
            st_d = S_ERROR;
            a_r  = mk_res(K_END, ts_q, 13'd0, 8'd0, ERR_NO_PREFIX, 1'b1);
          end else begin
            a_v     = 1'b1;
            a_r     = mk_res(K_CIDR, ts_q, vc_q, pv_q, ERR_NONE, 1'b0);
            do_idle = 1'b1;
          end
        end
        S_ERROR: st_d = S_ERROR;
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        b_v     = id_v;
        b_r     = id_r;
        st_d    = id_st;
        ts_d    = id_ts;
        vc_d    = id_vc;
        qs_d    = id_qs;
        dots_d  = id_dots;
        colon_d = id_colon;
        kw_d    = id_kw;
      end
      if (pos_q < POS_CAP) pos_d = pos_q + 12'd1;
    end
  end

  always_comb begin
    res0_o          = a_v ? a_r : b_r;
    res0_o.run_last = !(a_v && b_v);
    res1_o          = b_r;
    res1_o.run_last = 1'b1;
    res_v_o         = {a_v && b_v, a_v || b_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      qs_q    <= 1'b0;
      pos_q   <= 12'd0;
      ts_q    <= 12'd0;
      vc_q    <= 13'd0;
      dots_q  <= 3'd0;
      colon_q <= 1'b0;
      pv_q    <= 8'd0;
      phd_q   <= 1'b0;
      kw_q    <= 3'b111;
    end else if (acc_i) begin
      st_q    <= st_d;
      qs_q    <= qs_d;
      pos_q   <= pos_d;
      ts_q    <= ts_d;
      vc_q    <= vc_d;
      dots_q  <= dots_d;
      colon_q <= colon_d;
      pv_q    <= pv_d;
      phd_q   <= phd_d;
      kw_q    <= kw_d;
    end
  end

endmodule

@@ sv/qts_fifo.sv @@
// Four-entry result queue: takes up to two records per cycle, gives one.
// Depends on qts_pkg.
module qts_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    wr_v_i,
  input  qts_pkg::res_t wr0_i,
  input  qts_pkg::res_t wr1_i,
  output logic          space2_o,
  output logic          rd_v_o,
  input  logic          rd_ready_i,
  output qts_pkg::res_t rd_o
);
  import qts_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [2:0] n_wr;

  assign pop      = rd_v_o && rd_ready_i;
  assign n_wr     = {2'd0, wr_v_i[0]} + {2'd0, wr_v_i[1]};
  assign rd_v_o   = (cnt_q != 3'd0);
  assign rd_o     = mem_q[rp_q];
  assign space2_o = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (wr_v_i[0]) mem_q[wp_q] <= wr0_i;
    if (wr_v_i[1]) mem_q[wp_q + 2'd1] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_q + n_wr[1:0];
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + n_wr - {2'd0, pop};
    end
  end

endmodule

@@ sv/query_token_scanner_unit.sv @@
// Query token scanner: takes one query character (or the end-of-query word)
// per cycle while input ready is high and delivers token records through a
// four-entry result queue, one record per cycle while the output is ready.
// A character that yields one record or none is taken every cycle; one that
// closes a pending token and yields two records needs two output transfers,
// so a long run of them is paced by the output port.
// Input ready is low while the queue holds more than two records.
// Depends on qts_pkg, qts_if, qts_scan and qts_fifo.
module query_token_scanner_unit #(
  parameter int unsigned MAX_QUERY_LEN = qts_pkg::MAX_QUERY_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qts_in_if.sink      in_i,
  qts_out_if.source   out_o
);
  import qts_pkg::*;

  logic       acc;
  logic       space2;
  res_t       res0, res1, head;
  logic [1:0] res_v;

  assign in_i.ready = space2;
  assign acc        = in_i.valid && space2;

  qts_scan #(
    .MAX_QUERY_LEN(MAX_QUERY_LEN)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .mode_i  (in_i.mode),
    .char_i  (in_i.char_in),
    .res0_o  (res0),
    .res1_o  (res1),
    .res_v_o (res_v)
  );

  qts_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_v_i     (res_v & {2{acc}}),
    .wr0_i      (res0),
    .wr1_i      (res1),
    .space2_o   (space2),
    .rd_v_o     (out_o.valid),
    .rd_ready_i (out_o.ready),
    .rd_o       (head)
  );

  assign out_o.token_kind   = head.token_kind;
  assign out_o.tok_start    = head.tok_start;
  assign out_o.value_length = head.value_length;
  assign out_o.prefix_len   = head.prefix_len;
  assign out_o.error_code   = head.error_code;
  assign out_o.run_last     = head.run_last;
  assign out_o.query_done   = head.query_done;

endmodule

@@ sv/qts_checker.sv @@
// Port-level checks for the query token scanner, bound to the top level.
// Depends on qts_pkg and query_token_scanner_unit.
module qts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  token_kind,
  input logic [11:0] tok_start,
  input logic [12:0] value_length,
  input logic [7:0]  prefix_len,
  input logic [2:0]  error_code,
  input logic        run_last,
  input logic        query_done
);
  import qts_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(tok_start) &&
      $stable(value_length) && $stable(prefix_len) && $stable(error_code) &&
      $stable(run_last) && $stable(query_done))
    else $error("result changed while stalled");

  // the word that ends a query is always the last of its character
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && query_done |-> run_last)
    else $error("query end not last result");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && error_code != ERR_NONE |->
      token_kind == K_END && value_length == 13'd0 && query_done)
    else $error("malformed error result");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && token_kind != K_CIDR |-> prefix_len == 8'd0)
    else $error("prefix on non-cidr token");

endmodule

bind query_token_scanner_unit qts_checker u_qts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .token_kind   (out_o.token_kind),
  .tok_start    (out_o.tok_start),
  .value_length (out_o.value_length),
  .prefix_len   (out_o.prefix_len),
  .error_code   (out_o.error_code),
  .run_last     (out_o.run_last),
  .query_done   (out_o.query_done)
);
